### hdl/ttsl_pkg.sv
// Shared types and constants of the state-ordered LRU translation table.
// Holds the item structs, action and status codes, sequencer states and defaults.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ttsl_pkg;

    // default sizes of the table
    localparam int DEF_ENTRIES     = 64;
    localparam int DEF_STATE_COUNT = 4;
    localparam int DEF_TAG_BITS    = 48;
    localparam int DEF_ADDR_BITS   = 48;

    // fixed widths of the item fields
    localparam int FIELD_TAG_W   = 48;
    localparam int FIELD_ADDR_W  = 48;
    localparam int FIELD_IDX_W   = 6;
    localparam int FIELD_STATE_W = 2;
    localparam int WIDE_W        = 64;
    localparam int INT_W         = 32;

    typedef enum logic [1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_SHIFT  = 2'd2,
        ACT_RESET  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISS     = 2'd1,
        ST_NO_FREE  = 2'd2,
        ST_CONFLICT = 2'd3
    } t_status;

    typedef struct packed {
        t_action                  action;
        logic [FIELD_TAG_W-1:0]   tag;
        logic [FIELD_ADDR_W-1:0]  base_address;
        logic [FIELD_IDX_W-1:0]   entry_number;
        logic [FIELD_STATE_W-1:0] target_state;
    } t_cmd;

    typedef struct packed {
        t_status                  status;
        logic [FIELD_IDX_W-1:0]   result_index;
        logic [FIELD_ADDR_W-1:0]  result_address;
        logic [FIELD_STATE_W-1:0] result_state;
    } t_result;

    // per-entry verdict of the shared slot unit
    typedef struct packed {
        logic tag_hit;
        logic free_head;
        logic shift_down;
    } t_slot_flags;

    typedef enum logic [3:0] {
        SQ_CLEAR,
        SQ_IDLE,
        SQ_SEARCH,
        SQ_DECIDE,
        SQ_PEEK,
        SQ_UPDATE,
        SQ_DROP,
        SQ_APPEND,
        SQ_DONE
    } t_seq;

endpackage

`default_nettype wire

### hdl/ttsl_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ttsl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hdl/ttsl_slot_unit.sv
// Shared per-entry compare unit: tag match, free-order head and rank close-up test.
// Depends on ttsl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ttsl_slot_unit import ttsl_pkg::*; #(
    parameter int ENTRIES     = DEF_ENTRIES,
    parameter int STATE_COUNT = DEF_STATE_COUNT,
    parameter int TAG_BITS    = DEF_TAG_BITS
) (
    input  wire logic [TAG_BITS-1:0]            i_tag,
    input  wire logic [TAG_BITS-1:0]            i_key,
    input  wire logic [$clog2(STATE_COUNT)-1:0] i_state,
    input  wire logic [$clog2(ENTRIES)-1:0]     i_rank,
    input  wire logic [$clog2(ENTRIES)-1:0]     i_index,
    input  wire logic [$clog2(ENTRIES)-1:0]     i_rm_index,
    input  wire logic [$clog2(STATE_COUNT)-1:0] i_rm_state,
    input  wire logic [$clog2(ENTRIES)-1:0]     i_rm_rank,
    output t_slot_flags                         o_flags
);

    // live entry holding the key
    assign o_flags.tag_hit    = (i_state != '0) && (i_tag == i_key);
    // oldest free entry
    assign o_flags.free_head  = (i_state == '0) && (i_rank == '0);
    // younger entry of the same order closes the gap left by the removed one
    assign o_flags.shift_down = (i_index != i_rm_index) && (i_state == i_rm_state)
                                && (i_rank > i_rm_rank);

endmodule

`default_nettype wire

### hdl/translation_table_with_state_lru.sv
// Top level of the fully associative translation table with per-state LRU orders.
// Depends on ttsl_pkg, ttsl_ram and ttsl_slot_unit.
`timescale 1ns / 1ps
`default_nettype none

// Each entry holds a tag, an address, a state and a rank within its state's LRU
// order; tag, address and state/rank live in three RAMs, and one sequencer walks
// the tag and state/rank RAMs one entry per cycle through a single shared compare
// unit. After reset the block runs a clearing pass over the state/rank RAM with
// busy high. An item is taken when start is high and busy is low; busy then stays
// high until its result is out. A lookup or insert runs a search pass over all
// entries and, if it changes the table, a rank update pass; a shift or reset
// peeks at its entry and, if accepted, runs the rank update pass. The result
// is shown for exactly one cycle with o_strobe and cannot be held off; the next
// item may be started in that same cycle.
module translation_table_with_state_lru import ttsl_pkg::*; #(
    parameter int ENTRIES     = DEF_ENTRIES,
    parameter int STATE_COUNT = DEF_STATE_COUNT,
    parameter int TAG_BITS    = DEF_TAG_BITS,
    parameter int ADDR_BITS   = DEF_ADDR_BITS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_cmd i_cmd,
    output logic      busy,
    output logic      o_strobe,
    output t_result   o_result
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = IW + 1;
    localparam int SW = $clog2(STATE_COUNT);
    localparam int QW = $clog2(ENTRIES + 1);
    localparam int MW = SW + IW;

    // sequencer and scan pipeline
    t_seq              r_seq, n_seq;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_dv, n_dv;
    logic [IW-1:0]     r_didx, n_didx;

    // latched item and search results
    t_cmd              r_cmd, n_cmd;
    logic [TAG_BITS-1:0] r_key, n_key;
    logic              r_hit, n_hit;
    logic [IW-1:0]     r_hit_idx, n_hit_idx;
    logic [SW-1:0]     r_hit_state, n_hit_state;
    logic [IW-1:0]     r_hit_rank, n_hit_rank;
    logic              r_free, n_free;
    logic [IW-1:0]     r_free_idx, n_free_idx;

    // entry being moved and its orders
    logic [IW-1:0]     r_rm_idx, n_rm_idx;
    logic [SW-1:0]     r_rm_state, n_rm_state;
    logic [IW-1:0]     r_rm_rank, n_rm_rank;
    logic [SW-1:0]     r_app_state, n_app_state;
    t_status           r_status, n_status;

    logic [QW-1:0]     r_qlen [STATE_COUNT];
    logic [QW-1:0]     n_qlen [STATE_COUNT];

    t_result           r_out, n_out;
    logic              r_strobe, n_strobe;

    // ram ports
    logic              meta_we;
    logic [IW-1:0]     meta_waddr;
    logic [MW-1:0]     meta_wdata;
    logic [IW-1:0]     meta_raddr;
    logic [MW-1:0]     meta_rdata;
    logic              tag_we;
    logic [TAG_BITS-1:0] tag_rdata;
    logic              addr_we;
    logic [IW-1:0]     addr_waddr;
    logic [IW-1:0]     addr_raddr;
    logic [ADDR_BITS-1:0] addr_rdata;

    // field conversions
    logic [WIDE_W-1:0] w_tag_wide;
    logic [WIDE_W-1:0] w_base_wide;
    logic [WIDE_W-1:0] w_addr_out_wide;
    logic [INT_W-1:0]  w_entry_wide;
    logic [INT_W-1:0]  w_tgt_wide;
    logic [INT_W-1:0]  w_idx_out_wide;
    logic [INT_W-1:0]  w_state_out_wide;
    logic [IW-1:0]     w_entry_idx;
    logic              w_entry_ok;
    logic [SW-1:0]     w_tgt;
    logic              w_tgt_in_range;
    logic [SW-1:0]     m_state;
    logic [IW-1:0]     m_rank;
    logic [SW-1:0]     q_sel;
    logic [QW-1:0]     q_len_sel;
    t_slot_flags       w_flags;

    assign w_tag_wide       = WIDE_W'(i_cmd.tag);
    assign w_base_wide      = WIDE_W'(r_cmd.base_address);
    assign w_addr_out_wide  = WIDE_W'(addr_rdata);
    assign w_entry_wide     = INT_W'(i_cmd.entry_number);
    assign w_tgt_wide       = INT_W'(r_cmd.target_state);
    assign w_idx_out_wide   = INT_W'(r_rm_idx);
    assign w_state_out_wide = INT_W'(r_app_state);
    assign w_entry_idx      = w_entry_wide[IW-1:0];
    assign w_entry_ok       = w_entry_wide < INT_W'(ENTRIES);
    assign w_tgt            = w_tgt_wide[SW-1:0];
    assign w_tgt_in_range   = w_tgt_wide < INT_W'(STATE_COUNT);
    assign m_state          = meta_rdata[MW-1:IW];
    assign m_rank           = meta_rdata[IW-1:0];

    // one queue length read port, chosen by the sequencer step
    assign q_sel     = (r_seq == SQ_DROP) ? r_rm_state : r_app_state;
    assign q_len_sel = r_qlen[q_sel];

    // slot rams
    ttsl_ram #(.WIDTH(MW), .DEPTH(ENTRIES)) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (meta_waddr),
        .i_wdata (meta_wdata),
        .i_raddr (meta_raddr),
        .o_rdata (meta_rdata)
    );

    ttsl_ram #(.WIDTH(TAG_BITS), .DEPTH(ENTRIES)) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (r_free_idx),
        .i_wdata (r_key),
        .i_raddr (r_cnt[IW-1:0]),
        .o_rdata (tag_rdata)
    );

    ttsl_ram #(.WIDTH(ADDR_BITS), .DEPTH(ENTRIES)) u_addr_ram (
        .i_clk   (i_clk),
        .i_we    (addr_we),
        .i_waddr (addr_waddr),
        .i_wdata (w_base_wide[ADDR_BITS-1:0]),
        .i_raddr (addr_raddr),
        .o_rdata (addr_rdata)
    );

    // shared compare unit on the entry read last cycle
    ttsl_slot_unit #(
        .ENTRIES     (ENTRIES),
        .STATE_COUNT (STATE_COUNT),
        .TAG_BITS    (TAG_BITS)
    ) u_slot_unit (
        .i_tag      (tag_rdata),
        .i_key      (r_key),
        .i_state    (m_state),
        .i_rank     (m_rank),
        .i_index    (r_didx),
        .i_rm_index (r_rm_idx),
        .i_rm_state (r_rm_state),
        .i_rm_rank  (r_rm_rank),
        .o_flags    (w_flags)
    );

    // state register and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq    <= SQ_CLEAR;
            r_cnt    <= '0;
            r_dv     <= 1'b0;
            r_strobe <= 1'b0;
            r_hit    <= 1'b0;
            r_free   <= 1'b0;
            for (int q = 0; q < STATE_COUNT; q++) begin
                r_qlen[q] <= (q == 0) ? QW'(ENTRIES) : '0;
            end
        end else begin
            r_seq    <= n_seq;
            r_cnt    <= n_cnt;
            r_dv     <= n_dv;
            r_strobe <= n_strobe;
            r_hit    <= n_hit;
            r_free   <= n_free;
            r_qlen   <= n_qlen;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_didx      <= n_didx;
        r_cmd       <= n_cmd;
        r_key       <= n_key;
        r_hit_idx   <= n_hit_idx;
        r_hit_state <= n_hit_state;
        r_hit_rank  <= n_hit_rank;
        r_free_idx  <= n_free_idx;
        r_rm_idx    <= n_rm_idx;
        r_rm_state  <= n_rm_state;
        r_rm_rank   <= n_rm_rank;
        r_app_state <= n_app_state;
        r_status    <= n_status;
        r_out       <= n_out;
    end

    // sequencer: next state, ram control and result
    always_comb begin
        n_seq       = r_seq;
        n_cnt       = r_cnt;
        n_dv        = 1'b0;
        n_didx      = r_didx;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_hit_state = r_hit_state;
        n_hit_rank  = r_hit_rank;
        n_free      = r_free;
        n_free_idx  = r_free_idx;
        n_rm_idx    = r_rm_idx;
        n_rm_state  = r_rm_state;
        n_rm_rank   = r_rm_rank;
        n_app_state = r_app_state;
        n_status    = r_status;
        n_qlen      = r_qlen;
        n_out       = r_out;
        n_strobe    = 1'b0;
        meta_we     = 1'b0;
        meta_waddr  = r_didx;
        meta_wdata  = {m_state, m_rank - IW'(1)};
        meta_raddr  = r_cnt[IW-1:0];
        tag_we      = 1'b0;
        addr_we     = 1'b0;
        addr_waddr  = r_rm_idx;
        addr_raddr  = r_rm_idx;

        unique case (r_seq)
            // clearing pass: every entry free, rank equal to its index
            SQ_CLEAR: begin
                meta_we    = 1'b1;
                meta_waddr = r_cnt[IW-1:0];
                meta_wdata = {{SW{1'b0}}, r_cnt[IW-1:0]};
                if (r_cnt == CW'(ENTRIES - 1)) begin
                    n_cnt = '0;
                    n_seq = SQ_IDLE;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            // take an item; shifts peek at their entry right away
            SQ_IDLE: begin
                meta_raddr = w_entry_idx;
                if (start) begin
                    n_cmd    = i_cmd;
                    n_key    = w_tag_wide[TAG_BITS-1:0];
                    n_hit    = 1'b0;
                    n_free   = 1'b0;
                    n_cnt    = '0;
                    n_rm_idx = w_entry_idx;
                    if (i_cmd.action == ACT_LOOKUP || i_cmd.action == ACT_INSERT) begin
                        n_seq = SQ_SEARCH;
                    end else if (!w_entry_ok) begin
                        n_status = ST_MISS;
                        n_seq    = SQ_DONE;
                    end else begin
                        n_seq = SQ_PEEK;
                    end
                end
            end
            // walk all entries for the first tag hit and the oldest free entry
            SQ_SEARCH: begin
                if (r_cnt < CW'(ENTRIES)) begin
                    n_cnt  = r_cnt + CW'(1);
                    n_dv   = 1'b1;
                    n_didx = r_cnt[IW-1:0];
                end
                if (r_dv) begin
                    if (w_flags.tag_hit && !r_hit) begin
                        n_hit       = 1'b1;
                        n_hit_idx   = r_didx;
                        n_hit_state = m_state;
                        n_hit_rank  = m_rank;
                    end
                    if (w_flags.free_head && !r_free) begin
                        n_free     = 1'b1;
                        n_free_idx = r_didx;
                    end
                    if (r_cnt == CW'(ENTRIES)) begin
                        n_seq = SQ_DECIDE;
                    end
                end
            end
            // judge a lookup or insert from the search
            SQ_DECIDE: begin
                n_cnt = '0;
                if (r_cmd.action == ACT_LOOKUP) begin
                    if (!r_hit) begin
                        n_status = ST_MISS;
                        n_seq    = SQ_DONE;
                    end else begin
                        n_rm_idx    = r_hit_idx;
                        n_rm_state  = r_hit_state;
                        n_rm_rank   = r_hit_rank;
                        n_app_state = r_hit_state;
                        n_seq       = SQ_UPDATE;
                    end
                end else if (r_hit || r_cmd.target_state == '0 || !w_tgt_in_range) begin
                    n_status = ST_CONFLICT;
                    n_seq    = SQ_DONE;
                end else if (r_qlen[0] == '0 || !r_free) begin
                    n_status = ST_NO_FREE;
                    n_seq    = SQ_DONE;
                end else begin
                    tag_we      = 1'b1;
                    addr_we     = 1'b1;
                    addr_waddr  = r_free_idx;
                    n_rm_idx    = r_free_idx;
                    n_rm_state  = '0;
                    n_rm_rank   = '0;
                    n_app_state = w_tgt;
                    n_seq       = SQ_UPDATE;
                end
            end
            // judge a shift from the entry's current state
            SQ_PEEK: begin
                n_cnt = '0;
                if (!w_tgt_in_range || m_state == w_tgt) begin
                    n_status = ST_CONFLICT;
                    n_seq    = SQ_DONE;
                end else begin
                    addr_we     = (r_cmd.action == ACT_RESET);
                    n_rm_state  = m_state;
                    n_rm_rank   = m_rank;
                    n_app_state = w_tgt;
                    n_seq       = SQ_UPDATE;
                end
            end
            // close the gap in the old order, read-modify-write one entry a cycle
            SQ_UPDATE: begin
                if (r_cnt < CW'(ENTRIES)) begin
                    n_cnt  = r_cnt + CW'(1);
                    n_dv   = 1'b1;
                    n_didx = r_cnt[IW-1:0];
                end
                if (r_dv) begin
                    meta_we = w_flags.shift_down;
                    if (r_cnt == CW'(ENTRIES)) begin
                        n_seq = SQ_DROP;
                    end
                end
            end
            // shorten the old order
            SQ_DROP: begin
                if (q_len_sel != '0) begin
                    n_qlen[q_sel] = q_len_sel - QW'(1);
                end
                n_seq = SQ_APPEND;
            end
            // place the entry at the young end of the new order
            SQ_APPEND: begin
                meta_we       = 1'b1;
                meta_waddr    = r_rm_idx;
                meta_wdata    = {r_app_state, q_len_sel[IW-1:0]};
                n_qlen[q_sel] = q_len_sel + QW'(1);
                n_status      = ST_OK;
                n_seq         = SQ_DONE;
            end
            // present the result item
            SQ_DONE: begin
                n_strobe = 1'b1;
                n_out.status = r_status;
                if (r_status == ST_OK) begin
                    n_out.result_index   = w_idx_out_wide[FIELD_IDX_W-1:0];
                    n_out.result_address = w_addr_out_wide[FIELD_ADDR_W-1:0];
                    n_out.result_state   = w_state_out_wide[FIELD_STATE_W-1:0];
                end else begin
                    n_out.result_index   = '0;
                    n_out.result_address = '0;
                    n_out.result_state   = '0;
                end
                n_seq = SQ_IDLE;
            end
            default: begin
                n_seq = SQ_IDLE;
            end
        endcase
    end

    assign busy     = (r_seq != SQ_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

    // total of all order lengths, for checking only
    logic [QW+SW-1:0] w_qsum;
    always_comb begin
        w_qsum = '0;
        for (int q = 0; q < STATE_COUNT; q++) begin
            w_qsum = w_qsum + (QW+SW)'(r_qlen[q]);
        end
    end

    // a result is a single-cycle strobe
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held for more than one cycle");

    // an accepted item keeps the block busy
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but block not busy");

    // error results carry zero fields
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status != ST_OK) |->
        (o_result.result_index == '0 && o_result.result_address == '0
         && o_result.result_state == '0))
        else $error("error result with nonzero fields");

    // between items every entry sits in exactly one order
    a_orders_cover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == SQ_IDLE) |-> (w_qsum == (QW+SW)'(ENTRIES)))
        else $error("order lengths do not add up to the entry count");

endmodule

`default_nettype wire

### verif/ttsl_checker.sv
// Checker of the state-ordered LRU translation table: predicts and compares every result item.
// Depends on ttsl_pkg; instantiated next to the block by translation_table_with_state_lru_tb.
`timescale 1ns / 1ps

module ttsl_checker import ttsl_pkg::*; #(
    parameter int ENTRIES     = DEF_ENTRIES,
    parameter int STATE_COUNT = DEF_STATE_COUNT
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_start,
    input  wire t_cmd                                  i_cmd,
    input  wire logic                                  i_busy,
    input  wire logic                                  i_strobe,
    input  wire t_result                               i_result,
    output int                                         o_mismatches,
    output int                                         o_awaited,
    output logic [ENTRIES-1:0][FIELD_STATE_W-1:0]      o_slot_state,
    output logic [ENTRIES-1:0]                         o_tag_written
);

    // shadow copy of the table
    logic [FIELD_TAG_W-1:0]   m_tag     [ENTRIES];
    logic [FIELD_ADDR_W-1:0]  m_addr    [ENTRIES];
    logic [FIELD_STATE_W-1:0] m_state   [ENTRIES];
    int unsigned              m_rank    [ENTRIES];
    logic                     m_written [ENTRIES];
    int unsigned              m_len     [STATE_COUNT];

    t_result awaited_results[$];
    int      mismatch_total = 0;

    assign o_mismatches = mismatch_total;

    // one line per wrong field, counted
    task automatic report_mismatch(input string what, input logic [63:0] want_v,
                                   input logic [63:0] got_v);
        $display("[%0t] result %s: expected %0h, got %0h", $time, what, want_v, got_v);
        mismatch_total++;
    endtask

    // table after reset: all free, free order by index
    function automatic void clear_table();
        for (int k = 0; k < ENTRIES; k++) begin
            m_tag[k]     = '0;
            m_addr[k]    = '0;
            m_state[k]   = '0;
            m_rank[k]    = k;
            m_written[k] = 1'b0;
        end
        for (int s = 0; s < STATE_COUNT; s++) m_len[s] = 0;
        m_len[0] = ENTRIES;
    endfunction

    // take an entry out of its state's order and close the gap
    function automatic void unlink(int i);
        int          s;
        int unsigned r;
        s = m_state[i];
        r = m_rank[i];
        for (int k = 0; k < ENTRIES; k++) begin
            if (k != i && m_state[k] == m_state[i] && m_rank[k] > r) m_rank[k]--;
        end
        if (m_len[s] > 0) m_len[s]--;
    endfunction

    // append an entry at the most recent end of a state
    function automatic void link(int i, logic [FIELD_STATE_W-1:0] s);
        m_state[i] = s;
        m_rank[i]  = m_len[s];
        m_len[s]++;
    endfunction

    // in-use entry holding a tag, -1 if none
    function automatic int tag_owner(logic [FIELD_TAG_W-1:0] tg);
        for (int k = 0; k < ENTRIES; k++) begin
            if (m_state[k] != '0 && m_tag[k] == tg) return k;
        end
        return -1;
    endfunction

    function automatic t_result shape_result(t_status st, int idx);
        t_result r;
        r        = '0;
        r.status = st;
        if (st == ST_OK) begin
            r.result_index   = FIELD_IDX_W'(idx);
            r.result_address = m_addr[idx];
            r.result_state   = m_state[idx];
        end
        return r;
    endfunction

    // expected result of one item; updates the shadow table
    function automatic t_result translate_item(t_cmd c);
        int                       hit;
        int                       pick;
        int                       e;
        logic [FIELD_STATE_W-1:0] s;
        case (c.action)
            ACT_LOOKUP: begin
                hit = tag_owner(c.tag);
                if (hit < 0) return shape_result(ST_MISS, 0);
                s = m_state[hit];
                unlink(hit);
                link(hit, s);
                return shape_result(ST_OK, hit);
            end
            ACT_INSERT: begin
                if (tag_owner(c.tag) >= 0) return shape_result(ST_CONFLICT, 0);
                if (c.target_state == '0 || int'(c.target_state) >= STATE_COUNT)
                    return shape_result(ST_CONFLICT, 0);
                if (m_len[0] == 0) return shape_result(ST_NO_FREE, 0);
                pick = -1;
                for (int k = 0; k < ENTRIES; k++) begin
                    if (pick < 0 && m_state[k] == '0 && m_rank[k] == 0) pick = k;
                end
                if (pick < 0) return shape_result(ST_NO_FREE, 0);
                unlink(pick);
                link(pick, c.target_state);
                m_tag[pick]     = c.tag;
                m_addr[pick]    = c.base_address;
                m_written[pick] = 1'b1;
                return shape_result(ST_OK, pick);
            end
            default: begin
                // shift, or address reset followed by shift
                e = int'(c.entry_number);
                if (e >= ENTRIES) return shape_result(ST_MISS, 0);
                if (int'(c.target_state) >= STATE_COUNT || m_state[e] == c.target_state)
                    return shape_result(ST_CONFLICT, 0);
                if (c.action == ACT_RESET) m_addr[e] = c.base_address;
                unlink(e);
                link(e, c.target_state);
                return shape_result(ST_OK, e);
            end
        endcase
    endfunction

    // compare the result item of this edge, then predict the item taken at it
    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            clear_table();
            awaited_results.delete();
        end else begin
            if (i_strobe === 1'b1) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("with no item pending", '0, 64'(i_result.result_index));
                end else begin
                    want = awaited_results.pop_front();
                    if (i_result.status !== want.status)
                        report_mismatch("status", 64'(want.status), 64'(i_result.status));
                    if (i_result.result_index !== want.result_index)
                        report_mismatch("index", 64'(want.result_index),
                                        64'(i_result.result_index));
                    if (i_result.result_address !== want.result_address)
                        report_mismatch("address", 64'(want.result_address),
                                        64'(i_result.result_address));
                    if (i_result.result_state !== want.result_state)
                        report_mismatch("state", 64'(want.result_state),
                                        64'(i_result.result_state));
                end
            end
            if (i_start === 1'b1 && i_busy === 1'b0) begin
                awaited_results.push_back(translate_item(i_cmd));
            end
        end
        // views for the stimulus side, visible after this edge
        o_awaited <= awaited_results.size();
        for (int k = 0; k < ENTRIES; k++) begin
            o_slot_state[k]  <= m_state[k];
            o_tag_written[k] <= m_written[k];
        end
    end

endmodule

### verif/translation_table_with_state_lru_tb.sv
// Testbench top of the state-ordered LRU translation table: clock, reset, stimulus, verdict.
// Depends on ttsl_pkg, translation_table_with_state_lru and ttsl_checker.
`timescale 1ns / 1ps

module translation_table_with_state_lru_tb;
    import ttsl_pkg::*;

    localparam int ENTRIES     = DEF_ENTRIES;
    localparam int STATE_COUNT = DEF_STATE_COUNT;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int PHASE_ITEMS = 300;
    localparam int POOL_DEPTH  = 48;

    typedef enum logic {
        MIX_FILL,
        MIX_DRAIN
    } t_mix;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_cmd    i_cmd   = '0;
    logic    busy;
    logic    o_strobe;
    t_result o_result;

    int                                    mismatches;
    int                                    awaited;
    logic [ENTRIES-1:0][FIELD_STATE_W-1:0] slot_state_view;
    logic [ENTRIES-1:0]                    tag_written_view;

    int                     idle_pct    = 0;
    int                     cycle_count = 0;
    int                     action_sent [4];
    int                     status_seen [4];
    logic [FIELD_TAG_W-1:0] recent_tags[$];

    always #6 i_clk = ~i_clk;

    translation_table_with_state_lru #(
        .ENTRIES     (ENTRIES),
        .STATE_COUNT (STATE_COUNT)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    ttsl_checker #(
        .ENTRIES     (ENTRIES),
        .STATE_COUNT (STATE_COUNT)
    ) u_table_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_cmd         (i_cmd),
        .i_busy        (busy),
        .i_strobe      (o_strobe),
        .i_result      (o_result),
        .o_mismatches  (mismatches),
        .o_awaited     (awaited),
        .o_slot_state  (slot_state_view),
        .o_tag_written (tag_written_view)
    );

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // status tally for the summary
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1) begin
            status_seen[o_result.status] <= status_seen[o_result.status] + 1;
        end
    end

    function automatic t_cmd make_cmd(t_action act, logic [FIELD_TAG_W-1:0] tg,
                                      logic [FIELD_ADDR_W-1:0] ad,
                                      logic [FIELD_IDX_W-1:0] en,
                                      logic [FIELD_STATE_W-1:0] ts);
        t_cmd c;
        c.action       = act;
        c.tag          = tg;
        c.base_address = ad;
        c.entry_number = en;
        c.target_state = ts;
        return c;
    endfunction

    // 48-bit value, now and then an extreme
    function automatic logic [47:0] rand48();
        logic [63:0] w;
        int          sel;
        sel = $urandom_range(19);
        w   = {$urandom, $urandom};
        if (sel == 0) return '0;
        if (sel == 1) return '1;
        return w[47:0];
    endfunction

    // mostly an entry in use, else any entry
    function automatic logic [FIELD_IDX_W-1:0] pick_entry();
        int base;
        int k;
        base = $urandom_range(ENTRIES - 1);
        if ($urandom_range(99) < 80) begin
            for (k = 0; k < ENTRIES; k++) begin
                if (slot_state_view[(base + k) % ENTRIES] != '0)
                    return FIELD_IDX_W'((base + k) % ENTRIES);
            end
        end
        return FIELD_IDX_W'(base);
    endfunction

    // a free entry whose tag was never written must stay free
    function automatic t_cmd legal_cmd(t_cmd raw);
        t_cmd c;
        c = raw;
        if (c.action == ACT_SHIFT || c.action == ACT_RESET) begin
            if (slot_state_view[c.entry_number] == '0 && c.target_state != '0
                    && !tag_written_view[c.entry_number])
                c.target_state = '0;
        end
        return c;
    endfunction

    function automatic t_cmd random_item(t_mix mix);
        t_cmd c;
        int   roll;
        roll           = $urandom_range(99);
        c.tag          = rand48();
        c.base_address = rand48();
        c.entry_number = FIELD_IDX_W'($urandom_range(ENTRIES - 1));
        c.target_state = FIELD_STATE_W'($urandom_range(STATE_COUNT - 1));
        if (mix == MIX_FILL) begin
            if (roll < 25)      c.action = ACT_LOOKUP;
            else if (roll < 75) c.action = ACT_INSERT;
            else if (roll < 92) c.action = ACT_SHIFT;
            else                c.action = ACT_RESET;
        end else begin
            if (roll < 30)      c.action = ACT_LOOKUP;
            else if (roll < 45) c.action = ACT_INSERT;
            else if (roll < 80) c.action = ACT_SHIFT;
            else                c.action = ACT_RESET;
        end
        case (c.action)
            ACT_LOOKUP: begin
                if (recent_tags.size() > 0 && $urandom_range(99) < 65)
                    c.tag = recent_tags[$urandom_range(recent_tags.size() - 1)];
            end
            ACT_INSERT: begin
                if (recent_tags.size() > 0 && $urandom_range(99) < 12)
                    c.tag = recent_tags[$urandom_range(recent_tags.size() - 1)];
                if ($urandom_range(99) < 90)
                    c.target_state = FIELD_STATE_W'($urandom_range(STATE_COUNT - 1, 1));
                else
                    c.target_state = '0;
            end
            default: begin
                c.entry_number = pick_entry();
                if (mix == MIX_DRAIN && $urandom_range(99) < 55) c.target_state = '0;
            end
        endcase
        return c;
    endfunction

    // optional gap, then hold the item until taken, then let the prediction settle
    task automatic issue_item(input t_cmd raw);
        t_cmd c;
        if ($urandom_range(99) < idle_pct) begin
            repeat ($urandom_range(160, 1)) @(posedge i_clk);
        end
        c = legal_cmd(raw);
        action_sent[c.action]++;
        if (c.action == ACT_INSERT) begin
            recent_tags.push_back(c.tag);
            if (recent_tags.size() > POOL_DEPTH) void'(recent_tags.pop_front());
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy !== 1'b0);
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (awaited != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every action, the miss and conflict paths
        issue_item(make_cmd(ACT_LOOKUP, '0, '0, '0, 2'd0));                   // miss on empty
        issue_item(make_cmd(ACT_INSERT, '0, '0, '0, 2'd1));
        issue_item(make_cmd(ACT_INSERT, '1, '1, '0, 2'd3));
        issue_item(make_cmd(ACT_LOOKUP, '1, '0, '0, 2'd0));
        issue_item(make_cmd(ACT_LOOKUP, '0, '0, '0, 2'd0));
        issue_item(make_cmd(ACT_INSERT, '1, 48'h1, '0, 2'd2));                // duplicate tag
        issue_item(make_cmd(ACT_INSERT, 48'h1234_5678, 48'h9, '0, 2'd0));     // insert to free
        issue_item(make_cmd(ACT_SHIFT, '0, '0, 6'd0, 2'd2));
        issue_item(make_cmd(ACT_SHIFT, '0, '0, 6'd0, 2'd2));                  // unchanged state
        issue_item(make_cmd(ACT_RESET, '0, 48'h5555_5555_5555, 6'd1, 2'd2));
        issue_item(make_cmd(ACT_RESET, '0, 48'haaaa_aaaa_aaaa, 6'd1, 2'd2));  // no address write
        issue_item(make_cmd(ACT_LOOKUP, '1, '0, '0, 2'd0));
        issue_item(make_cmd(ACT_SHIFT, '0, '0, 6'd63, 2'd0));                 // free to free
        issue_item(make_cmd(ACT_SHIFT, '0, '0, 6'd0, 2'd0));                  // drop to free
        issue_item(make_cmd(ACT_LOOKUP, '0, '0, '0, 2'd0));                   // dropped tag
        issue_item(make_cmd(ACT_INSERT, 48'habcd, 48'h8000_0000_0001, '0, 2'd2));
        issue_item(make_cmd(ACT_SHIFT, '0, '0, 6'd0, 2'd1));                  // back from free
        issue_item(make_cmd(ACT_LOOKUP, '0, '0, '0, 2'd0));
        issue_item(make_cmd(ACT_SHIFT, '0, '0, 6'd1, 2'd3));
        issue_item(make_cmd(ACT_RESET, '0, '0, 6'd2, 2'd1));
        issue_item(make_cmd(ACT_SHIFT, '0, '0, 6'd62, 2'd3));
        issue_item(make_cmd(ACT_INSERT, 48'h1, 48'h1, '0, 2'd3));
        issue_item(make_cmd(ACT_LOOKUP, 48'habcd, '0, '0, 2'd0));

        // random: three idling phases, each a fill stretch then a drain stretch
        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 36 : (ph == 1) ? 73 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                issue_item(random_item((n < PHASE_ITEMS / 2) ? MIX_FILL : MIX_DRAIN));
            end
            wait_drained();
        end

        // tail
        wait_drained();
        repeat (2 * ENTRIES + 16) @(posedge i_clk);

        $display("Covered %0d items: %0d lookups, %0d inserts, %0d shifts, %0d address resets",
                 action_sent[0] + action_sent[1] + action_sent[2] + action_sent[3],
                 action_sent[ACT_LOOKUP], action_sent[ACT_INSERT],
                 action_sent[ACT_SHIFT], action_sent[ACT_RESET]);
        $display("Statuses returned: %0d ok, %0d miss, %0d table full, %0d conflict",
                 status_seen[ST_OK], status_seen[ST_MISS],
                 status_seen[ST_NO_FREE], status_seen[ST_CONFLICT]);
        if (mismatches == 0 && awaited == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### files.f
hdl/ttsl_pkg.sv
hdl/ttsl_ram.sv
hdl/ttsl_slot_unit.sv
hdl/translation_table_with_state_lru.sv
verif/ttsl_checker.sv
verif/translation_table_with_state_lru_tb.sv
